@@ src/sws_pkg.sv @@
package sws_pkg;

  localparam int VALUE_BITS    = 16;
  localparam int SUM_BITS      = 20;
  localparam int COUNT_BITS    = 5;
  localparam int DIVISOR_BITS  = VALUE_BITS / 2 + 1;
  localparam int DEF_MAX_ITEMS = 16;

  localparam logic [VALUE_BITS-1:0]   SMALLEST_PRIME = VALUE_BITS'(2);
  localparam logic [DIVISOR_BITS-1:0] FIRST_DIVISOR  = DIVISOR_BITS'(2);
  localparam logic [SUM_BITS-1:0]     SUM_LIMIT      = {SUM_BITS{1'b1}};

  typedef enum logic [8:0] {
    ST_LOAD    = 9'b000000001,
    ST_SORT_RD = 9'b000000010,
    ST_SORT_CM = 9'b000000100,
    ST_SORT_WR = 9'b000001000,
    ST_EMIT_RD = 9'b000010000,
    ST_EMIT_LT = 9'b000100000,
    ST_PR_CHK  = 9'b001000000,
    ST_PR_DIV  = 9'b010000000,
    ST_EMIT_OUT = 9'b100000000
  } state_t;

endpackage

@@ src/sws_ram.sv @@
module sws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sort_with_stats_and_prime_flag.sv @@
// Collects a set of unsigned values, sorts it and streams it back out.
// Input channel (in_valid/in_stall): one value per beat, last_in marks the
// final value of a set. Values beyond MAX_ITEMS are dropped, though a
// marked one still ends the set. While loading, one beat is taken per cycle.
// After the marked beat, in_stall stays high until the whole set is out.
// The set is sorted in place in the element RAM by a bubble sort: each
// step reads one entry and then writes the smaller of it and the carried
// value one place lower; the carried maximum is written at each pass end.
// Each output beat then needs a RAM read and, for a value of two or more,
// a trial-division prime test: ST_PR_CHK and ST_PR_DIV run per divisor,
// from two up until its square exceeds the value or it divides it (up to
// 254 divisors for a 16-bit value).
// Output channel (out_valid/out_stall): one beat per element in ascending
// order with the maximum, sum and count of the set; last_out marks the end.
// A stalled output beat holds until taken; nothing else advances meanwhile.
// Reset returns the block to loading with an empty set; the RAM contents
// are not cleared, since only entries written in the current set are read.
module sort_with_stats_and_prime_flag
  import sws_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] sorted_value,
  output logic                  is_prime,
  output logic [VALUE_BITS-1:0] largest,
  output logic [SUM_BITS-1:0]   total,
  output logic [COUNT_BITS-1:0] item_count,
  output logic                  last_out
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int BW = $clog2(VALUE_BITS);

  state_t                    state;
  logic [CW-1:0]             count;
  logic [VALUE_BITS-1:0]     run_max;
  logic [SUM_BITS-1:0]       run_sum;
  logic [CW-1:0]             k;
  logic [CW-1:0]             lim;
  logic [CW-1:0]             e;
  logic [VALUE_BITS-1:0]     carry;
  logic [VALUE_BITS-1:0]     cur;
  logic                      prime;
  logic [DIVISOR_BITS-1:0]   div;
  logic [DIVISOR_BITS-1:0]   rem;
  logic [BW-1:0]             bitc;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [VALUE_BITS-1:0]     wdata;
  logic [AW-1:0]             raddr;
  logic [VALUE_BITS-1:0]     rdata;

  logic                      in_acc;
  logic                      out_acc;
  logic                      room;
  logic [CW-1:0]             count_next;
  logic [SUM_BITS:0]         sum_add;
  logic [VALUE_BITS-1:0]     lo_val;
  logic [VALUE_BITS-1:0]     hi_val;
  logic [DIVISOR_BITS:0]     rem_sh;
  logic [DIVISOR_BITS:0]     rem_next;
  logic [2*DIVISOR_BITS-1:0] div_sq;

  assign in_stall  = (state != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state == ST_EMIT_OUT);
  assign out_acc   = out_valid && !out_stall;
  assign room      = (count < CW'(MAX_ITEMS));
  assign count_next = room ? count + CW'(1) : count;
  assign sum_add   = {1'b0, run_sum} + (SUM_BITS + 1)'(value);

  assign lo_val = (carry < rdata) ? carry : rdata;
  assign hi_val = (carry < rdata) ? rdata : carry;

  assign rem_sh   = {rem, cur[bitc]};
  assign rem_next = (rem_sh >= {1'b0, div}) ? rem_sh - {1'b0, div} : rem_sh;
  assign div_sq   = div * div;

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = value;
    unique case (state)
      ST_LOAD: begin
        we = in_acc && room;
      end
      ST_SORT_CM: begin
        we    = (k != '0);
        waddr = AW'(k - CW'(1));
        wdata = lo_val;
      end
      ST_SORT_WR: begin
        we    = 1'b1;
        waddr = lim[AW-1:0];
        wdata = carry;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign raddr = (state == ST_EMIT_RD) ? e[AW-1:0] : k[AW-1:0];

  sws_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_ITEMS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      run_max <= '0;
      run_sum <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              count <= count_next;
              if (value > run_max) begin
                run_max <= value;
              end
              run_sum <= sum_add[SUM_BITS] ? SUM_LIMIT : sum_add[SUM_BITS-1:0];
            end
            if (last_in) begin
              e <= '0;
              k <= '0;
              lim <= count_next - CW'(1);
              if (count_next == '0) begin
                state <= ST_LOAD;
              end else if (count_next == CW'(1)) begin
                state <= ST_EMIT_RD;
              end else begin
                state <= ST_SORT_RD;
              end
            end
          end
        end
        ST_SORT_RD: begin
          state <= ST_SORT_CM;
        end
        ST_SORT_CM: begin
          carry <= (k == '0) ? rdata : hi_val;
          if (k == lim) begin
            state <= ST_SORT_WR;
          end else begin
            k     <= k + CW'(1);
            state <= ST_SORT_RD;
          end
        end
        ST_SORT_WR: begin
          k <= '0;
          if (lim == CW'(1)) begin
            state <= ST_EMIT_RD;
          end else begin
            lim   <= lim - CW'(1);
            state <= ST_SORT_RD;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LT;
        end
        ST_EMIT_LT: begin
          cur <= rdata;
          div <= FIRST_DIVISOR;
          if (rdata < SMALLEST_PRIME) begin
            prime <= 1'b0;
            state <= ST_EMIT_OUT;
          end else begin
            state <= ST_PR_CHK;
          end
        end
        ST_PR_CHK: begin
          rem  <= '0;
          bitc <= BW'(VALUE_BITS - 1);
          if (div_sq > (2*DIVISOR_BITS)'(cur)) begin
            prime <= 1'b1;
            state <= ST_EMIT_OUT;
          end else begin
            state <= ST_PR_DIV;
          end
        end
        ST_PR_DIV: begin
          rem <= rem_next[DIVISOR_BITS-1:0];
          if (bitc == '0) begin
            if (rem_next == '0) begin
              prime <= 1'b0;
              state <= ST_EMIT_OUT;
            end else begin
              div   <= div + DIVISOR_BITS'(1);
              state <= ST_PR_CHK;
            end
          end else begin
            bitc <= bitc - BW'(1);
          end
        end
        ST_EMIT_OUT: begin
          if (out_acc) begin
            if (last_out) begin
              count   <= '0;
              run_max <= '0;
              run_sum <= '0;
              state   <= ST_LOAD;
            end else begin
              e     <= e + CW'(1);
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  assign sorted_value = cur;
  assign is_prime     = prime;
  assign largest      = run_max;
  assign total        = run_sum;
  assign item_count   = COUNT_BITS'(count);
  assign last_out     = (e == count - CW'(1));

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_set_not_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0) && (e < count))
    else $error("result beat outside the stored set");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_acc && last_out) |=> !in_stall && (count == '0))
    else $error("set end did not return to loading");

endmodule
